/* sv/ptpq_pkg.sv */
// Package: widths, status and operation codes, and request, result, order and control types of the order queue.
`timescale 1ns / 1ps
package ptpq_pkg;
  localparam int unsigned CapacityDefault = 64;
  localparam int unsigned IdW = 31;
  localparam int unsigned PriceW = 32;
  localparam int unsigned TimeW = 48;
  localparam int unsigned VolW = 31;
  localparam int unsigned CountW = 7;
  localparam int unsigned EntryW = IdW + PriceW + TimeW + VolW + 1;

  localparam logic [1:0] StatusOk = 2'd0;
  localparam logic [1:0] StatusEmpty = 2'd1;
  localparam logic [1:0] StatusFull = 2'd2;

  localparam logic OpAdd = 1'b0;
  localparam logic OpPop = 1'b1;

  typedef struct packed {
    logic [IdW-1:0]    id;
    logic [PriceW-1:0] price;
    logic [TimeW-1:0]  ts;
    logic [VolW-1:0]   volume;
    logic              side;
  } order_t;

  typedef struct packed {
    logic              operation;
    logic [IdW-1:0]    order_id;
    logic [PriceW-1:0] order_price;
    logic [TimeW-1:0]  order_time;
    logic [VolW-1:0]   order_volume;
    logic              order_side;
  } request_t;

  typedef struct packed {
    logic [1:0]        status;
    logic [IdW-1:0]    best_id;
    logic [PriceW-1:0] best_price;
    logic [TimeW-1:0]  best_time;
    logic [VolW-1:0]   best_volume;
    logic              best_side;
    logic [CountW-1:0] held_count;
  } result_t;

  // controller to datapath
  typedef struct packed {
    logic clear_best; // start scan: take slot 0 as best
    logic scan_step;  // compare read slot against best
    logic write_add;  // write incoming order at tail
    logic shift_step; // copy slot+1 down to slot
    logic load_out;   // latch result
    logic ok_result;  // result carries best order
  } ctrl_t;
endpackage

/* sv/ptpq_if.sv */
// Valid/ready channel interface carrying one item of type T (a request or a result).
`timescale 1ns / 1ps
interface ptpq_if #(parameter type T = logic) ();
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

/* sv/ptpq_ram.sv */
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module ptpq_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];
  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    rdata_o <= mem_q[raddr_i];
  end
endmodule

/* sv/ptpq_datapath.sv */
// Datapath: order store, best-order scan register and result register.
`timescale 1ns / 1ps
module ptpq_datapath #(
  parameter int unsigned Capacity = 64
) (
  input  logic                      clk_i,
  input  ptpq_pkg::ctrl_t           ctrl_i,
  input  ptpq_pkg::order_t          add_order_i,
  input  logic [$clog2(Capacity)-1:0] waddr_i,
  input  logic [$clog2(Capacity)-1:0] raddr_i,
  input  logic [$clog2(Capacity)-1:0] rd_slot_i,
  output logic [$clog2(Capacity)-1:0] best_slot_o,
  output ptpq_pkg::order_t          best_o
);
  import ptpq_pkg::*;
  localparam int unsigned AW = $clog2(Capacity);

  order_t rdata, wdata, best_q, best_d, out_q;
  logic [AW-1:0] bslot_q, bslot_d;
  logic ahead;

  assign wdata = ctrl_i.write_add ? add_order_i : rdata;

  ptpq_ram #(.Width(EntryW), .Depth(Capacity)) u_store (
    .clk_i, .we_i(ctrl_i.write_add | ctrl_i.shift_step), .waddr_i,
    .wdata_i(wdata), .raddr_i, .rdata_o(rdata)
  );

  // strict ordering: earlier slot wins full ties since scan runs upward
  assign ahead = (rdata.price > best_q.price) ||
                 ((rdata.price == best_q.price) && (rdata.ts < best_q.ts));

  always_comb begin
    best_d = best_q;
    bslot_d = bslot_q;
    if (ctrl_i.clear_best) begin
      best_d = rdata;
      bslot_d = '0;
    end else if (ctrl_i.scan_step && ahead) begin
      best_d = rdata;
      bslot_d = rd_slot_i;
    end
  end

  always_ff @(posedge clk_i) begin
    best_q <= best_d;
    bslot_q <= bslot_d;
    if (ctrl_i.load_out) out_q <= ctrl_i.ok_result ? best_q : '0;
  end

  assign best_slot_o = bslot_q;
  assign best_o = out_q;
endmodule

/* sv/ptpq_ctrl.sv */
// Controller: sequences add, scan and compaction, drives the handshakes.
`timescale 1ns / 1ps
module ptpq_ctrl #(
  parameter int unsigned Capacity = 64
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  input  logic                        in_op_i,
  output logic                        in_ready_o,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [1:0]                  status_o,
  output logic [ptpq_pkg::CountW-1:0] count_o,
  output ptpq_pkg::ctrl_t             ctrl_o,
  output logic [$clog2(Capacity)-1:0] waddr_o,
  output logic [$clog2(Capacity)-1:0] raddr_o,
  output logic [$clog2(Capacity)-1:0] rd_slot_o,
  input  logic [$clog2(Capacity)-1:0] best_slot_i
);
  import ptpq_pkg::*;
  localparam int unsigned AW = $clog2(Capacity);
  localparam int unsigned OW = $clog2(Capacity + 1);

  localparam logic [2:0] SIdle  = 3'd0;
  localparam logic [2:0] SFirst = 3'd1;
  localparam logic [2:0] SScan  = 3'd2;
  localparam logic [2:0] SShift = 3'd3;
  localparam logic [2:0] SOut   = 3'd4;
  localparam logic [2:0] SShRd  = 3'd5;

  logic [2:0] state_q, state_d;
  logic [OW-1:0] occ_q, occ_d;
  logic [OW-1:0] idx_q, idx_d; // read slot in flight
  logic [AW-1:0] wptr_q, wptr_d;
  logic [1:0] status_q, status_d;
  logic accept;

  assign in_ready_o = (state_q == SIdle);
  assign accept = in_valid_i & in_ready_o;
  assign out_valid_o = (state_q == SOut);
  assign status_o = status_q;
  assign count_o = CountW'(occ_q);
  assign rd_slot_o = idx_q[AW-1:0];

  always_comb begin
    state_d = state_q;
    occ_d = occ_q;
    idx_d = idx_q;
    wptr_d = wptr_q;
    status_d = status_q;
    ctrl_o = '0;
    waddr_o = wptr_q;
    raddr_o = '0;
    unique case (state_q)
      SIdle: begin
        if (accept) begin
          ctrl_o.load_out = 1'b1;
          ctrl_o.ok_result = 1'b0;
          if (in_op_i == OpAdd) begin
            if (occ_q == OW'(Capacity)) begin
              status_d = StatusFull;
            end else begin
              status_d = StatusOk;
              ctrl_o.write_add = 1'b1;
              waddr_o = occ_q[AW-1:0];
              occ_d = occ_q + 1'b1;
            end
            state_d = SOut;
          end else if (occ_q == '0) begin
            status_d = StatusEmpty;
            state_d = SOut;
          end else begin
            status_d = StatusOk;
            raddr_o = '0;
            idx_d = '0;
            state_d = SFirst;
          end
        end
      end
      SFirst: begin
        // slot 0 data is out; request slot 1
        ctrl_o.clear_best = 1'b1;
        raddr_o = AW'(1);
        idx_d = OW'(1);
        state_d = (occ_q == OW'(1)) ? SShift : SScan;
        wptr_d = '0;
      end
      SScan: begin
        ctrl_o.scan_step = 1'b1;
        if (idx_q + 1'b1 < occ_q) begin
          raddr_o = AW'(idx_q + 1'b1);
          idx_d = idx_q + 1'b1;
        end else begin
          state_d = SShift;
        end
      end
      SShift: begin
        // latch best, then compact slots above it
        ctrl_o.load_out = 1'b1;
        ctrl_o.ok_result = 1'b1;
        wptr_d = best_slot_i;
        if (OW'(best_slot_i) + 1'b1 < occ_q) begin
          raddr_o = AW'(OW'(best_slot_i) + 1'b1);
          state_d = SShRd;
        end else begin
          occ_d = occ_q - 1'b1;
          state_d = SOut;
        end
      end
      SShRd: begin
        ctrl_o.shift_step = 1'b1;
        waddr_o = wptr_q;
        wptr_d = wptr_q + 1'b1;
        if (OW'(wptr_q) + 2'd2 < occ_q) begin
          raddr_o = AW'(OW'(wptr_q) + 2'd2);
        end else begin
          occ_d = occ_q - 1'b1;
          state_d = SOut;
        end
      end
      SOut: begin
        if (out_ready_i) state_d = SIdle;
      end
      default: state_d = SIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SIdle;
      occ_q <= '0;
      idx_q <= '0;
      wptr_q <= '0;
      status_q <= StatusOk;
    end else begin
      state_q <= state_d;
      occ_q <= occ_d;
      idx_q <= idx_d;
      wptr_q <= wptr_d;
      status_q <= status_d;
    end
  end
endmodule

/* sv/price_time_priority_queue.sv */
// Top level of the price-time priority order queue.
// Requests enter on the in channel: operation 0 adds an order, 1 pops the
// best order (highest price, then earliest timestamp, then earliest add).
// Each request gives one result on the out channel with a status, the
// popped order (zero on add or error) and the count held afterward.
// One request is handled at a time. An add or a rejected request goes
// straight from idle to the result state. A pop of n held orders scans the store
// through the RAM read port, one slot a cycle, then compacts the slots
// above the popped one a cycle each.
// The result waits in its register while out_ready_i is low, and no new
// request is taken until it has been delivered.
// Reset empties the queue at once; stored slots need no clearing.
`timescale 1ns / 1ps
module price_time_priority_queue #(
  parameter int unsigned CAPACITY = ptpq_pkg::CapacityDefault
) (
  input  logic clk_i,
  input  logic rst_ni,
  ptpq_if.sink   in_i,
  ptpq_if.source out_o
);
  import ptpq_pkg::*;
  localparam int unsigned AW = $clog2(CAPACITY);

  ctrl_t ctrl;
  logic [AW-1:0] waddr, raddr, rd_slot, best_slot;
  order_t add_order, best;
  logic [1:0] status;
  logic [CountW-1:0] count;

  assign add_order.id = in_i.data.order_id;
  assign add_order.price = in_i.data.order_price;
  assign add_order.ts = in_i.data.order_time;
  assign add_order.volume = in_i.data.order_volume;
  assign add_order.side = in_i.data.order_side;

  ptpq_ctrl #(.Capacity(CAPACITY)) u_ctrl (
    .clk_i, .rst_ni, .in_valid_i(in_i.valid), .in_op_i(in_i.data.operation),
    .in_ready_o(in_i.ready), .out_valid_o(out_o.valid), .out_ready_i(out_o.ready),
    .status_o(status), .count_o(count), .ctrl_o(ctrl), .waddr_o(waddr),
    .raddr_o(raddr), .rd_slot_o(rd_slot), .best_slot_i(best_slot)
  );

  ptpq_datapath #(.Capacity(CAPACITY)) u_dp (
    .clk_i, .ctrl_i(ctrl), .add_order_i(add_order), .waddr_i(waddr),
    .raddr_i(raddr), .rd_slot_i(rd_slot), .best_slot_o(best_slot), .best_o(best)
  );

  assign out_o.data.status = status;
  assign out_o.data.best_id = best.id;
  assign out_o.data.best_price = best.price;
  assign out_o.data.best_time = best.ts;
  assign out_o.data.best_volume = best.volume;
  assign out_o.data.best_side = best.side;
  assign out_o.data.held_count = count;

  a_ready_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> !in_i.ready) else $error("request taken while result pending");
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && !out_o.ready |=> out_o.valid && $stable(out_o.data.held_count))
    else $error("stalled result changed");
  a_empty_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.data.status == StatusEmpty |-> out_o.data.held_count == '0)
    else $error("empty status with nonzero count");
endmodule

/* tb/sv/price_time_priority_queue_test.sv */
// Testbench: checks the order queue's add and pop results against a packed-slot predictor.
`timescale 1ns / 1ps
module price_time_priority_queue_test;
  import ptpq_pkg::*;

  localparam int unsigned Depth = CapacityDefault;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  ptpq_if #(.T(request_t)) req_if ();
  ptpq_if #(.T(result_t))  res_if ();

  price_time_priority_queue #(.CAPACITY(Depth)) dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (req_if.sink),
    .out_o (res_if.source)
  );

  // predictor state: slots packed in insertion order
  order_t  book[$];
  result_t pending_results[$];
  int      mismatches = 0;
  bit      no_idle = 1'b0;

  initial begin
    req_if.valid = 1'b0;
    req_if.data = '0;
    res_if.ready = 1'b0;
  end

  function automatic result_t apply_request(logic op, order_t order);
    result_t r;
    int best_slot;
    r = '0;
    if (op == OpAdd) begin
      if (book.size() >= Depth) r.status = StatusFull;
      else book.push_back(order);
    end else if (book.size() == 0) begin
      r.status = StatusEmpty;
    end else begin
      best_slot = 0;
      for (int i = 1; i < book.size(); i++) begin
        if (book[i].price > book[best_slot].price ||
            (book[i].price == book[best_slot].price && book[i].ts < book[best_slot].ts))
          best_slot = i;
      end
      r.best_id = book[best_slot].id;
      r.best_price = book[best_slot].price;
      r.best_time = book[best_slot].ts;
      r.best_volume = book[best_slot].volume;
      r.best_side = book[best_slot].side;
      book.delete(best_slot);
    end
    r.held_count = CountW'(book.size());
    return r;
  endfunction

  task automatic send_request(logic op, order_t order);
    request_t req;
    int gap;
    req.operation = op;
    req.order_id = order.id;
    req.order_price = order.price;
    req.order_time = order.ts;
    req.order_volume = order.volume;
    req.order_side = order.side;
    gap = no_idle ? 0 : $urandom_range(0, 13);
    if (gap > 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    req_if.valid <= 1'b1;
    req_if.data <= req;
    do @(posedge clk_i); while (!req_if.ready);
    pending_results.push_back(apply_request(op, order));
  endtask

  function automatic order_t random_order(bit narrow);
    order_t o;
    o.id = IdW'($urandom());
    o.price = narrow ? 32'($urandom_range(0, 3)) : $urandom();
    o.ts = narrow ? 48'($urandom_range(0, 3)) : 48'({$urandom(), $urandom()});
    o.volume = VolW'($urandom());
    o.side = 1'($urandom_range(0, 1));
    return o;
  endfunction

  task automatic wait_drained();
    req_if.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  // receiver side: random stall before each result
  initial begin
    int stall;
    @(posedge rst_ni);
    forever begin
      stall = no_idle ? 0 : $urandom_range(0, 13);
      if (stall > 0) begin
        res_if.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      res_if.ready <= 1'b1;
      do @(posedge clk_i); while (!res_if.valid);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && res_if.valid && res_if.ready) begin
      result_t e;
      result_t a;
      a = res_if.data;
      if (pending_results.size() == 0) begin
        $error("result with no request outstanding: %p", a);
        mismatches++;
      end else begin
        e = pending_results.pop_front();
        if (a.status !== e.status) begin
          $error("status exp %0d got %0d", e.status, a.status); mismatches++;
        end
        if (a.best_id !== e.best_id) begin
          $error("best_id exp %0d got %0d", e.best_id, a.best_id); mismatches++;
        end
        if (a.best_price !== e.best_price) begin
          $error("best_price exp %0d got %0d", e.best_price, a.best_price); mismatches++;
        end
        if (a.best_time !== e.best_time) begin
          $error("best_time exp %0d got %0d", e.best_time, a.best_time); mismatches++;
        end
        if (a.best_volume !== e.best_volume) begin
          $error("best_volume exp %0d got %0d", e.best_volume, a.best_volume);
          mismatches++;
        end
        if (a.best_side !== e.best_side) begin
          $error("best_side exp %0d got %0d", e.best_side, a.best_side); mismatches++;
        end
        if (a.held_count !== e.held_count) begin
          $error("held_count exp %0d got %0d", e.held_count, a.held_count); mismatches++;
        end
      end
    end
  end

  task automatic test_empty_pop();
    send_request(OpPop, random_order(1'b0));
  endtask

  task automatic test_field_extremes();
    send_request(OpAdd, '0);
    send_request(OpAdd, '1);
    send_request(OpPop, '0);
    send_request(OpPop, '1);
    send_request(OpPop, '0);
  endtask

  task automatic test_tie_breaks();
    order_t o;
    o = '0;
    o.price = 32'd500;
    o.ts = 48'd100;
    for (int i = 0; i < 4; i++) begin
      o.id = 31'(i + 1);
      o.side = i[0];
      send_request(OpAdd, o);
    end
    o.ts = 48'd50;
    o.id = 31'd9;
    send_request(OpAdd, o);
    o.price = 32'd501;
    o.ts = 48'd900;
    o.id = 31'd10;
    send_request(OpAdd, o);
    repeat (7) send_request(OpPop, o);
  endtask

  task automatic test_full_store();
    for (int i = 0; i < Depth; i++) send_request(OpAdd, random_order(1'b1));
    send_request(OpAdd, random_order(1'b0));
    send_request(OpAdd, '1);
    // hold until every result is back, then drain
    wait_drained();
    for (int i = 0; i <= Depth; i++) send_request(OpPop, random_order(1'b0));
  endtask

  task automatic test_random_traffic(int n_items);
    int add_pct;
    for (int i = 0; i < n_items; i++) begin
      if (i % 100 == 0) begin
        add_pct = $urandom_range(20, 85);
        no_idle = ($urandom_range(0, 3) == 0);
      end
      send_request(($urandom_range(0, 99) < add_pct) ? OpAdd : OpPop,
                   random_order($urandom_range(0, 2) == 0));
    end
    no_idle = 1'b0;
  endtask

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_empty_pop();
    test_field_extremes();
    test_tie_breaks();
    test_full_store();
    test_random_traffic(800);
    wait_drained();
    repeat (2 * Depth + 10) @(posedge clk_i);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("price_time_priority_queue regression: pass");
    end else begin
      $display("price_time_priority_queue regression: fail");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("price_time_priority_queue regression: fail");
    $finish;
  end
endmodule
